### rtl/rmts_pkg.sv
package rmts_pkg;

    localparam int TASK_SLOTS = 4;
    localparam int TASK_W     = 2;
    localparam int DATA_W     = 16;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_PERIOD_TASK0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WORK_TASK0   = 3'd4;

    localparam logic [DATA_W-1:0] PERIOD_RESET = 16'd1;
    localparam logic [DATA_W-1:0] WORK_RESET   = 16'd0;

    typedef struct packed {
        logic [TASK_SLOTS-1:0][DATA_W-1:0] period;
        logic [TASK_SLOTS-1:0][DATA_W-1:0] work;
    } cfg_t;

    typedef struct packed {
        logic                  busy_res;
        logic [TASK_W-1:0]     running_task;
        logic [TASK_SLOTS-1:0] released_mask;
        logic [TASK_SLOTS-1:0] missed_mask;
    } result_t;

endpackage

### rtl/rmts_tick_if.sv
interface rmts_tick_if;

    logic valid;
    logic ready;
    logic tick;

    modport source (output valid, output tick, input ready);
    modport sink (input valid, input tick, output ready);

endinterface

### rtl/rmts_result_if.sv
interface rmts_result_if;

    logic                              valid;
    logic                              ready;
    logic                              busy_res;
    logic [rmts_pkg::TASK_W-1:0]       running_task;
    logic [rmts_pkg::TASK_SLOTS-1:0]   released_mask;
    logic [rmts_pkg::TASK_SLOTS-1:0]   missed_mask;

    modport source (
        output valid, output busy_res, output running_task,
        output released_mask, output missed_mask, input ready
    );
    modport sink (
        input valid, input busy_res, input running_task,
        input released_mask, input missed_mask, output ready
    );

endinterface

### rtl/rate_monotonic_tick_scheduler.sv
// Tick beats pass a stage-one register; each result then waits in the output register.
// Throughput: one tick beat per cycle, sustained while the result side keeps taking beats.
// The per-task phase and work counters do not limit the rate; they update once per tick.
// Reset (rst_n low, asynchronous) clears all counters and both pipeline stages.
// Reset also returns every period to one and every execution time to zero.
module rate_monotonic_tick_scheduler #(
    parameter int NUM_TASKS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    rmts_tick_if.sink                        ticks,
    rmts_result_if.source                    results,
    input  logic                             cfg_we,
    input  logic [rmts_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [rmts_pkg::DATA_W-1:0]      cfg_wdata
);

    localparam logic [rmts_pkg::TASK_SLOTS-1:0] ACTIVE_MASK =
        rmts_pkg::TASK_SLOTS'((1 << NUM_TASKS) - 1);

    rmts_pkg::cfg_t     cfg;
    rmts_pkg::result_t  sched_result;
    rmts_pkg::result_t  res_reg;
    logic               s1_valid_reg;
    logic               s1_tick_reg;
    logic               out_valid_reg;
    logic               out_free;
    logic               step;

    rmts_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    rmts_sched #(
        .NUM_TASKS (NUM_TASKS)
    ) u_sched (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .tick   (s1_tick_reg),
        .cfg    (cfg),
        .result (sched_result)
    );

    assign out_free    = !out_valid_reg || results.ready;
    assign step        = s1_valid_reg && out_free;
    assign ticks.ready = !s1_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ticks.valid && ticks.ready)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (step)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ticks.valid && ticks.ready)
        begin
            s1_tick_reg <= ticks.tick;
        end
        if (step)
        begin
            res_reg <= sched_result;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.busy_res      = res_reg.busy_res;
    assign results.running_task  = res_reg.running_task;
    assign results.released_mask = res_reg.released_mask;
    assign results.missed_mask   = res_reg.missed_mask;

`ifndef NO_ASSERTIONS
    a_idle_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (results.valid && !results.busy_res) |-> (results.running_task == '0))
        else $error("idle result reports a nonzero task");

    a_unused_masks: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (((results.released_mask | results.missed_mask) & ~ACTIVE_MASK) == '0))
        else $error("mask bit set for an unused task");

    a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> (results.valid && (res_reg == $past(sched_result))))
        else $error("result beat lost or corrupted on its way to the output register");
`endif

endmodule

### rtl/rmts_cfg_regs.sv
module rmts_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [rmts_pkg::REG_IDX_W-1:0]   cfg_index,
    input  logic [rmts_pkg::DATA_W-1:0]      cfg_wdata,
    output rmts_pkg::cfg_t                   cfg
);

    rmts_pkg::cfg_t                cfg_reg;
    logic [rmts_pkg::TASK_W-1:0]   slot;

    assign slot = cfg_index[rmts_pkg::TASK_W-1:0];
    assign cfg  = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rmts_pkg::TASK_SLOTS; i++)
            begin
                cfg_reg.period[i] <= rmts_pkg::PERIOD_RESET;
                cfg_reg.work[i]   <= rmts_pkg::WORK_RESET;
            end
        end
        else if (cfg_we)
        begin
            if (cfg_index >= rmts_pkg::REG_WORK_TASK0)
            begin
                cfg_reg.work[slot] <= cfg_wdata;
            end
            else
            begin
                cfg_reg.period[slot] <= cfg_wdata;
            end
        end
    end

endmodule

### rtl/rmts_sched.sv
module rmts_sched #(
    parameter int NUM_TASKS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               tick,
    input  rmts_pkg::cfg_t     cfg,
    output rmts_pkg::result_t  result
);

    logic [rmts_pkg::DATA_W-1:0] phase_reg     [NUM_TASKS];
    logic [rmts_pkg::DATA_W-1:0] work_left_reg [NUM_TASKS];
    logic [rmts_pkg::DATA_W-1:0] phase_next    [NUM_TASKS];
    logic [rmts_pkg::DATA_W-1:0] work_left_next[NUM_TASKS];

    logic [rmts_pkg::DATA_W-1:0]     work_rel[NUM_TASKS];
    logic [rmts_pkg::TASK_SLOTS-1:0] released;
    logic [rmts_pkg::TASK_SLOTS-1:0] missed;
    logic                            busy;
    logic [rmts_pkg::TASK_W-1:0]     sel;

    always_comb
    begin
        logic [rmts_pkg::DATA_W:0] phase_inc;
        released = '0;
        missed   = '0;
        busy     = 1'b0;
        sel      = '0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            released[i] = (phase_reg[i] == '0);
            work_rel[i] = released[i] ? cfg.work[i] : work_left_reg[i];
        end
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if ((work_rel[i] != '0) && (!busy || (cfg.period[i] < cfg.period[sel])))
            begin
                busy = 1'b1;
                sel  = rmts_pkg::TASK_W'(i);
            end
        end
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            if (busy && (sel == rmts_pkg::TASK_W'(i)))
            begin
                work_left_next[i] = work_rel[i] - 1'b1;
            end
            else
            begin
                work_left_next[i] = work_rel[i];
            end
            phase_inc = {1'b0, phase_reg[i]} + 1'b1;
            if (phase_inc >= {1'b0, cfg.period[i]})
            begin
                missed[i]     = (work_left_next[i] != '0);
                phase_next[i] = '0;
            end
            else
            begin
                phase_next[i] = phase_inc[rmts_pkg::DATA_W-1:0];
            end
        end
    end

    always_comb
    begin
        result = '0;
        if (tick)
        begin
            result.busy_res      = busy;
            result.running_task  = sel;
            result.released_mask = released;
            result.missed_mask   = missed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                phase_reg[i]     <= '0;
                work_left_reg[i] <= '0;
            end
        end
        else if (step && tick)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                phase_reg[i]     <= phase_next[i];
                work_left_reg[i] <= work_left_next[i];
            end
        end
    end

endmodule
